>>> design/ghal_pkg.sv
// ----------------------------------------------------------------------------
// ghal_pkg: shared types and constants of the generational handle allocator
// Sizes of the handle tables, request codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ghal_pkg;

  localparam int MAX_HANDLES = 1024;
  localparam int IDX_W       = $clog2(MAX_HANDLES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int GEN_BITS    = 16;
  localparam int GEN_W       = GEN_BITS;
  localparam int MODE_W      = 2;
  localparam int VER_W       = 16;
  localparam int CMP_W       = (GEN_W > VER_W) ? GEN_W : VER_W;
  localparam int POS_W       = IDX_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_HANDLES);
  localparam logic [GEN_W-1:0] GEN_ONE = GEN_W'(1);

  localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic read;
    logic exec;
    logic clear;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic destroy_go;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> design/generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit: slot map handle allocator
// Creates, destroys and checks index/generation handles with a free stack
// and a dense list of live handles.
// ----------------------------------------------------------------------------
//  channel  valid        stall        payload
//  in       in_valid_i   in_stall_o   mode_i, handle_index_i, handle_version_i
//  out      out_valid_o  out_stall_i  out_index_o, out_version_o, ok_o,
//                                     live_count_o
//
// create, check and a refused destroy step through read, execute and finish;
// a destroy that frees a handle adds a clear step before finish: the single
// read and write port of each table sets these steps.
// reset takes effect at once; the fresh index mark stands in for clearing
// the generation and position tables, so no clearing pass runs.
// a stalled result waits in the output register while the next beat is
// taken; that item then waits in its finish step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_allocator_unit import ghal_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [IDX_W-1:0]  handle_index_i,
  input  wire logic [VER_W-1:0]  handle_version_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [IDX_W-1:0]  out_index_o,
  output logic      [VER_W-1:0]  out_version_o,
  output logic                   ok_o,
  output logic      [CNT_W-1:0]  live_count_o
);

  cmd_t    cmd;
  status_t status;

  ghal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ghal_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .mode_i           (mode_i),
    .handle_index_i   (handle_index_i),
    .handle_version_i (handle_version_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_index_o      (out_index_o),
    .out_version_o    (out_version_o),
    .ok_o             (ok_o),
    .live_count_o     (live_count_o)
  );

endmodule

`default_nettype wire

>>> design/ghal_ram.sv
// ----------------------------------------------------------------------------
// ghal_ram: simple dual-port ram
// One write port and one read port, read data registered, no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ghal_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/ghal_ctrl.sv
// ----------------------------------------------------------------------------
// ghal_ctrl: request sequencer
// Steps each request through read, execute, optional clear and finish.
// ----------------------------------------------------------------------------
`default_nettype none

module ghal_ctrl import ghal_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ:  state_d = ST_EXEC;
      ST_EXEC: begin
        state_d = status_i.destroy_go ? ST_CLEAR : ST_FINISH;
      end
      ST_CLEAR: state_d = ST_FINISH;
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:   cmd_o.accept = in_valid_i;
      ST_READ:   cmd_o.read   = 1'b1;
      ST_EXEC:   cmd_o.exec   = 1'b1;
      ST_CLEAR:  cmd_o.clear  = 1'b1;
      ST_FINISH: cmd_o.load   = status_i.out_free;
      default:   cmd_o        = '0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

>>> design/ghal_dp.sv
// ----------------------------------------------------------------------------
// ghal_dp: allocator datapath
// Request registers, counters, the four handle tables and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ghal_dp import ghal_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output status_t                status_o,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [IDX_W-1:0]  handle_index_i,
  input  wire logic [VER_W-1:0]  handle_version_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [IDX_W-1:0]  out_index_o,
  output logic      [VER_W-1:0]  out_version_o,
  output logic                   ok_o,
  output logic      [CNT_W-1:0]  live_count_o
);

  // request
  logic [MODE_W-1:0] mode_q;
  logic [IDX_W-1:0]  idx_q;
  logic [VER_W-1:0]  ver_q;

  // allocator counters
  logic [CNT_W-1:0] free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0] fresh_q, fresh_d;
  logic [CNT_W-1:0] dense_cnt_q, dense_cnt_d;

  // per-request scratch
  logic             n_fresh_q, full_q, known_q;
  logic [IDX_W-1:0] res_idx_q;
  logic [GEN_W-1:0] res_ver_q;
  logic             res_ok_q;

  // result register
  logic             out_valid_q;
  logic [IDX_W-1:0] out_index_q;
  logic [VER_W-1:0] out_version_q;
  logic             ok_q;
  logic [CNT_W-1:0] live_q;

  // ram ports
  logic             gen_we, gen_re, pos_we, pos_re;
  logic             dense_we, dense_re, free_we, free_re;
  logic [IDX_W-1:0] gen_waddr, gen_raddr, pos_waddr, pos_raddr;
  logic [IDX_W-1:0] dense_waddr, dense_raddr, free_waddr, free_raddr;
  logic [GEN_W-1:0] gen_wdata, gen_rdata;
  logic [POS_W-1:0] pos_wdata, pos_rdata;
  logic [IDX_W-1:0] dense_wdata, dense_rdata, free_wdata, free_rdata;

  logic             is_create, is_destroy, is_check;
  logic [CNT_W-1:0] free_top, dense_top;
  logic [GEN_W-1:0] gen_cur, gen_next;
  logic             pos_live, destroy_go, ver_match;
  logic [IDX_W-1:0] pos_val, new_idx;

  assign is_create  = (mode_q == MODE_CREATE);
  assign is_destroy = (mode_q == MODE_DESTROY);
  assign is_check   = (mode_q == MODE_CHECK);
  assign free_top   = free_cnt_q - CNT_W'(1);
  assign dense_top  = dense_cnt_q - CNT_W'(1);

  // entries at or beyond the fresh mark were never written: reset values
  assign gen_cur    = known_q ? gen_rdata : GEN_ONE;
  assign gen_next   = gen_cur + GEN_ONE;
  assign pos_live   = known_q & pos_rdata[IDX_W];
  assign pos_val    = pos_rdata[IDX_W-1:0];
  assign destroy_go = is_destroy & pos_live & (dense_cnt_q != '0);
  assign ver_match  = (CMP_W'(ver_q) == CMP_W'(gen_cur));
  assign new_idx    = n_fresh_q ? fresh_q[IDX_W-1:0] : free_rdata;

  assign status_o.destroy_go = cmd_i.exec & destroy_go;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_i;
      idx_q  <= handle_index_i;
      ver_q  <= handle_version_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      n_fresh_q <= (free_cnt_q == '0);
      full_q    <= (free_cnt_q == '0) && (fresh_q == CNT_MAX);
      known_q   <= ({1'b0, idx_q} < fresh_q);
    end
  end

  // table reads and writes
  always_comb begin
    gen_we      = 1'b0;
    gen_waddr   = idx_q;
    gen_wdata   = gen_next;
    gen_re      = 1'b0;
    gen_raddr   = idx_q;
    pos_we      = 1'b0;
    pos_waddr   = idx_q;
    pos_wdata   = '0;
    pos_re      = 1'b0;
    pos_raddr   = idx_q;
    dense_we    = 1'b0;
    dense_waddr = dense_cnt_q[IDX_W-1:0];
    dense_wdata = new_idx;
    dense_re    = 1'b0;
    dense_raddr = dense_top[IDX_W-1:0];
    free_we     = 1'b0;
    free_waddr  = free_cnt_q[IDX_W-1:0];
    free_wdata  = idx_q;
    free_re     = 1'b0;
    free_raddr  = free_top[IDX_W-1:0];
    free_cnt_d  = free_cnt_q;
    fresh_d     = fresh_q;
    dense_cnt_d = dense_cnt_q;

    if (cmd_i.read) begin
      free_re  = is_create && (free_cnt_q != '0);
      gen_re   = is_destroy || is_check;
      pos_re   = is_destroy;
      dense_re = is_destroy;
    end

    if (cmd_i.exec && is_create && !full_q) begin
      pos_we      = 1'b1;
      pos_waddr   = new_idx;
      pos_wdata   = {1'b1, dense_cnt_q[IDX_W-1:0]};
      dense_we    = 1'b1;
      dense_cnt_d = dense_cnt_q + CNT_W'(1);
      if (n_fresh_q) begin
        gen_we    = 1'b1;
        gen_waddr = new_idx;
        gen_wdata = GEN_ONE;
        fresh_d   = fresh_q + CNT_W'(1);
      end else begin
        gen_re     = 1'b1;
        gen_raddr  = new_idx;
        free_cnt_d = free_top;
      end
    end

    if (cmd_i.exec && destroy_go) begin
      // last dense entry moves into the freed slot
      dense_we    = 1'b1;
      dense_waddr = pos_val;
      dense_wdata = dense_rdata;
      pos_we      = 1'b1;
      pos_waddr   = dense_rdata;
      pos_wdata   = {1'b1, pos_val};
      gen_we      = 1'b1;
      free_we     = (free_cnt_q != CNT_MAX);
      dense_cnt_d = dense_top;
      if (free_cnt_q != CNT_MAX) free_cnt_d = free_cnt_q + CNT_W'(1);
    end

    if (cmd_i.clear) begin
      pos_we    = 1'b1;
      pos_waddr = idx_q;
      pos_wdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_cnt_q  <= '0;
      fresh_q     <= '0;
      dense_cnt_q <= '0;
    end else begin
      free_cnt_q  <= free_cnt_d;
      fresh_q     <= fresh_d;
      dense_cnt_q <= dense_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_idx_q <= idx_q;
      res_ver_q <= '0;
      res_ok_q  <= 1'b0;
      case (mode_q)
        MODE_CREATE: begin
          if (!full_q) begin
            res_idx_q <= new_idx;
            res_ver_q <= GEN_ONE;
            res_ok_q  <= 1'b1;
          end
        end
        MODE_DESTROY: begin
          res_ver_q <= destroy_go ? gen_next : gen_cur;
          res_ok_q  <= destroy_go;
        end
        MODE_CHECK: begin
          res_ver_q <= gen_cur;
          res_ok_q  <= ver_match;
        end
        default: begin
          res_ver_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_index_q <= res_idx_q;
      // a reused index carries the generation read back during execute
      if (is_create && res_ok_q && !n_fresh_q) begin
        out_version_q <= VER_W'(gen_rdata);
      end else begin
        out_version_q <= VER_W'(res_ver_q);
      end
      ok_q   <= res_ok_q;
      live_q <= dense_cnt_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_index_q;
  assign out_version_o = out_version_q;
  assign ok_o          = ok_q;
  assign live_count_o  = live_q;

  ghal_ram #(.DATA_W(GEN_W), .ADDR_W(IDX_W)) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (gen_waddr),
    .wdata_i (gen_wdata),
    .re_i    (gen_re),
    .raddr_i (gen_raddr),
    .rdata_o (gen_rdata)
  );

  ghal_ram #(.DATA_W(POS_W), .ADDR_W(IDX_W)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  ghal_ram #(.DATA_W(IDX_W), .ADDR_W(IDX_W)) u_dense_ram (
    .clk_i   (clk_i),
    .we_i    (dense_we),
    .waddr_i (dense_waddr),
    .wdata_i (dense_wdata),
    .re_i    (dense_re),
    .raddr_i (dense_raddr),
    .rdata_o (dense_rdata)
  );

  ghal_ram #(.DATA_W(IDX_W), .ADDR_W(IDX_W)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (free_wdata),
    .re_i    (free_re),
    .raddr_i (free_raddr),
    .rdata_o (free_rdata)
  );

endmodule

`default_nettype wire

>>> design/ghal_checker.sv
// ----------------------------------------------------------------------------
// ghal_checker: port checks of the handle allocator
// Watches the top level ports for sequencing, count range, output hold and reset exit.
// ----------------------------------------------------------------------------
`default_nettype none

module ghal_checker import ghal_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [IDX_W-1:0]  out_index_o,
  input wire logic [VER_W-1:0]  out_version_o,
  input wire logic              ok_o,
  input wire logic [CNT_W-1:0]  live_count_o
);

  logic in_beat;

  assign in_beat = in_valid_i && !in_stall_o;

  // one request at a time: input held off through read and execute
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o ##1 in_stall_o)
    else $error("input taken again too soon after a beat");

  a_live_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (live_count_o <= CNT_MAX))
    else $error("live count beyond table size");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_index_o) &&
      $stable(out_version_o) && $stable(ok_o) && $stable(live_count_o))
    else $error("stalled result changed");

  a_no_result_at_reset_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result shown straight out of reset");

endmodule

bind generational_handle_allocator_unit ghal_checker u_ghal_checker (.*);

`default_nettype wire

>>> sim/generational_handle_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit_tb: self-checking bench of the allocator
// Drives create, destroy, check and unused-mode requests with random idling on both
// sides, predicts every reply from a software copy of the handle tables and
// compares the replies field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_allocator_unit_tb;
  import ghal_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VER_W-1:0] ver;
    logic             ok;
    logic [CNT_W-1:0] cnt;
  } reply_t;

  // software copy of the slot map plus the replies still owed by the block
  class handle_book;
    logic [GEN_W-1:0] gen_tbl [MAX_HANDLES];
    logic [POS_W-1:0] pos_tbl [MAX_HANDLES];
    bit               live    [MAX_HANDLES];
    logic [IDX_W-1:0] dense   [MAX_HANDLES];
    logic [IDX_W-1:0] free_stk[MAX_HANDLES];
    int               free_cnt;
    int               fresh_nxt;
    int               dense_cnt;
    reply_t           replies_due[$];
    int               errors;

    function new();
      for (int i = 0; i < MAX_HANDLES; i++) begin
        gen_tbl[i] = GEN_ONE;
        pos_tbl[i] = '0;
        live[i]    = 1'b0;
      end
      free_cnt  = 0;
      fresh_nxt = 0;
      dense_cnt = 0;
      errors    = 0;
    endfunction

    function void take_request(logic [MODE_W-1:0] m, logic [IDX_W-1:0] ix,
                               logic [VER_W-1:0] vr);
      reply_t           r;
      int               n;
      logic [POS_W-1:0] pos;
      logic [IDX_W-1:0] last;
      r.idx = ix;
      r.ver = '0;
      r.ok  = 1'b0;
      case (m)
        MODE_CREATE: begin
          n = -1;
          if (free_cnt > 0) begin
            free_cnt--;
            n = free_stk[free_cnt];
          end else if (fresh_nxt < MAX_HANDLES) begin
            n = fresh_nxt;
            fresh_nxt++;
          end
          if (n >= 0) begin
            pos_tbl[n]       = POS_W'(dense_cnt);
            live[n]          = 1'b1;
            dense[dense_cnt] = IDX_W'(n);
            dense_cnt++;
            r.idx = IDX_W'(n);
            r.ver = VER_W'(gen_tbl[n]);
            r.ok  = 1'b1;
          end
        end
        MODE_DESTROY: begin
          r.ver = VER_W'(gen_tbl[ix]);
          if (live[ix] && dense_cnt > 0) begin
            // last dense entry fills the hole; works when last is ix itself
            pos  = pos_tbl[ix];
            last = dense[dense_cnt-1];
            dense[pos]    = last;
            pos_tbl[last] = pos;
            dense_cnt--;
            live[ix]    = 1'b0;
            pos_tbl[ix] = '0;
            gen_tbl[ix] = gen_tbl[ix] + GEN_ONE;
            if (free_cnt < MAX_HANDLES) begin
              free_stk[free_cnt] = ix;
              free_cnt++;
            end
            r.ver = VER_W'(gen_tbl[ix]);
            r.ok  = 1'b1;
          end
        end
        MODE_CHECK: begin
          r.ver = VER_W'(gen_tbl[ix]);
          r.ok  = (CMP_W'(vr) == CMP_W'(gen_tbl[ix]));
        end
        default: ;
      endcase
      r.cnt = CNT_W'(dense_cnt);
      replies_due.insert(replies_due.size(), r);
    endfunction

    function void match_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none pending: expected nothing, actual %p", $time, got);
        errors++;
        return;
      end
      want = replies_due[0];
      replies_due.delete(0);
      if (got.idx !== want.idx) begin
        $display("%0t: out_index expected %0d actual %0d", $time, want.idx, got.idx);
        errors++;
      end
      if (got.ver !== want.ver) begin
        $display("%0t: out_version expected %0d actual %0d", $time, want.ver, got.ver);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
        errors++;
      end
      if (got.cnt !== want.cnt) begin
        $display("%0t: live_count expected %0d actual %0d", $time, want.cnt, got.cnt);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [MODE_W-1:0] mode_i;
  logic [IDX_W-1:0]  handle_index_i;
  logic [VER_W-1:0]  handle_version_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [IDX_W-1:0]  out_index_o;
  logic [VER_W-1:0]  out_version_o;
  logic              ok_o;
  logic [CNT_W-1:0]  live_count_o;

  handle_book book = new();
  bit         idle_on;
  int         hold_reqs;

  generational_handle_allocator_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .handle_index_i   (handle_index_i),
    .handle_version_i (handle_version_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_index_o      (out_index_o),
    .out_version_o    (out_version_o),
    .ok_o             (ok_o),
    .live_count_o     (live_count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // one request beat; valid stays high into the next call unless it idles
  task automatic send_request(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] ix,
                              input logic [VER_W-1:0] vr);
    @(negedge clk_i);
    if (idle_on && $urandom_range(99, 0) < 35) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    mode_i           = m;
    handle_index_i   = ix;
    handle_version_i = vr;
    do @(posedge clk_i); while (in_stall_o);
    book.take_request(m, ix, vr);
  endtask

  task automatic create_handle();
    send_request(MODE_CREATE, IDX_W'($urandom), VER_W'($urandom));
  endtask

  task automatic pick_live(output logic [IDX_W-1:0] ix);
    ix = book.dense[$urandom_range(book.dense_cnt - 1, 0)];
  endtask

  // reply side: random stall, plus one long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = idle_on && ($urandom_range(99, 0) < 35);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      book.match_reply('{out_index_o, out_version_o, ok_o, live_count_o});
    end
  end

  initial begin
    #40000000;
    $display("[generational_handle_allocator_unit] ERROR");
    $finish;
  end

  initial begin
    logic [IDX_W-1:0] ix;
    int               p;
    bit               grow;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    mode_i           = MODE_CREATE;
    handle_index_i   = '0;
    handle_version_i = '0;
    idle_on          = 1'b1;
    hold_reqs        = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: untouched and dead indexes, reuse order, stale handles
    send_request(MODE_CHECK, 10'd0, 16'd1);
    send_request(MODE_CHECK, 10'd1023, 16'hFFFF);
    send_request(MODE_DESTROY, 10'd5, 16'd0);
    send_request(MODE_UNUSED, 10'd1023, 16'hFFFF);
    send_request(MODE_CREATE, 10'd1023, 16'hFFFF);
    send_request(MODE_CREATE, 10'd0, 16'd0);
    create_handle();
    send_request(MODE_CHECK, 10'd1, 16'd1);
    send_request(MODE_DESTROY, 10'd0, 16'd0);
    send_request(MODE_CHECK, 10'd0, 16'd1);
    send_request(MODE_DESTROY, 10'd0, 16'hFFFF);
    create_handle();
    send_request(MODE_DESTROY, 10'd2, 16'd0);
    send_request(MODE_DESTROY, 10'd1, 16'd0);
    create_handle();
    create_handle();
    send_request(MODE_CHECK, 10'd2, 16'd2);
    send_request(MODE_CHECK, 10'd0, 16'd0);
    send_request(MODE_DESTROY, 10'd1023, 16'd0);
    send_request(MODE_UNUSED, 10'd0, 16'd0);

    // fill to capacity with no idling, reply side held off at first
    idle_on = 1'b0;
    hold_reqs++;
    while (book.dense_cnt < MAX_HANDLES) create_handle();
    send_request(MODE_CREATE, 10'd1023, 16'hFFFF);
    send_request(MODE_CREATE, 10'd0, 16'd0);
    send_request(MODE_CHECK, 10'd1023, 16'd1);
    send_request(MODE_DESTROY, 10'd1023, 16'd0);
    send_request(MODE_DESTROY, 10'd512, 16'd0);
    create_handle();
    create_handle();

    // random traffic, drifting between draining and refilling
    idle_on = 1'b1;
    grow    = 1'b0;
    for (int n = 0; n < 250; n++) begin
      if (n % 50 == 0) grow = ~grow;
      p = $urandom_range(99, 0);
      if (p < (grow ? 45 : 20)) begin
        create_handle();
      end else if (p < 70 && book.dense_cnt > 0) begin
        pick_live(ix);
        send_request(MODE_DESTROY, ix, VER_W'($urandom));
      end else if (p < 83 && book.dense_cnt > 0) begin
        pick_live(ix);
        send_request(MODE_CHECK, ix, VER_W'(book.gen_tbl[ix]));
      end else if (p < 88 && book.dense_cnt > 0) begin
        pick_live(ix);
        send_request(MODE_CHECK, ix, VER_W'(book.gen_tbl[ix]) + VER_W'($urandom_range(65535, 1)));
      end else if (p < 93) begin
        send_request(MODE_DESTROY, IDX_W'($urandom), VER_W'($urandom));
      end else if (p < 97) begin
        send_request(MODE_CHECK, IDX_W'($urandom), VER_W'($urandom));
      end else begin
        send_request(MODE_UNUSED, IDX_W'($urandom), VER_W'($urandom));
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    idle_on    = 1'b1;
    while (book.replies_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("[generational_handle_allocator_unit] OK");
    end else begin
      $display("[generational_handle_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> generational_handle_allocator_unit.f
design/ghal_pkg.sv
design/ghal_ram.sv
design/ghal_ctrl.sv
design/ghal_dp.sv
design/generational_handle_allocator_unit.sv
design/ghal_checker.sv
sim/generational_handle_allocator_unit_tb.sv
